// ===== rtl/npc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg
// types and constants shared by the near-plane clipper modules
// ----------------------------------------------------------------------------
package npc_pkg;
   localparam int COORD_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   // the dividend d0 * 2^F needs COORD_BITS + 1 + F bits, plus a sign bit
   localparam int DIV_BITS      = COORD_BITS + FRACTION_BITS + 2;
   localparam int QCNT_BITS     = $clog2(DIV_BITS + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      coord_type w;
      coord_type u;
      coord_type v;
   } vertex_type;

   typedef struct packed {
      vertex_type vtx;
      logic       triangle_select;
      logic       last_of_run;
   } result_type;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_CLASSIFY,
      ST_PLAN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_LERP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;

   // saturate a wide signed value to the coordinate range
   function automatic coord_type sat_coord(input logic signed [DIV_BITS-1:0] val);
      logic signed [DIV_BITS-1:0] hi;
      logic signed [DIV_BITS-1:0] lo;
      hi = DIV_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
      lo = -hi - DIV_BITS'(1);
      if (val > hi) begin
         sat_coord = hi[COORD_BITS-1:0];
      end else if (val < lo) begin
         sat_coord = lo[COORD_BITS-1:0];
      end else begin
         sat_coord = val[COORD_BITS-1:0];
      end
   endfunction
endpackage
`default_nettype wire

// ===== rtl/npc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npc_vertex_if / npc_result_if
// valid/ready channels for vertex items and result items
// ----------------------------------------------------------------------------
interface npc_vertex_if;
   import npc_pkg::*;
   logic       valid;
   logic       ready;
   vertex_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface npc_result_if;
   import npc_pkg::*;
   logic       valid;
   logic       ready;
   result_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/npc_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npc_divider
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module npc_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic signed [npc_pkg::DIV_BITS-1:0]   dividend,
   input  wire logic signed [npc_pkg::DIV_BITS-1:0]   divisor,
   output      npc_pkg::div_ctl_type                  ctl,
   output      logic signed [npc_pkg::DIV_BITS-1:0]   quotient
);
   import npc_pkg::*;

   logic [DIV_BITS-1:0]  num_ff, num_in;
   logic [DIV_BITS-1:0]  den_ff, den_in;
   logic [DIV_BITS:0]    rem_ff, rem_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_BITS:0]    shifted;
   logic [DIV_BITS:0]    trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[DIV_BITS-1:0], num_ff[DIV_BITS-1]};
      trial   = shifted - {1'b0, den_ff};
      if (start) begin
         num_in  = dividend[DIV_BITS-1] ? DIV_BITS'(-dividend) : dividend;
         den_in  = divisor[DIV_BITS-1] ? DIV_BITS'(-divisor) : divisor;
         neg_in  = dividend[DIV_BITS-1] ^ divisor[DIV_BITS-1];
         rem_in  = '0;
         cnt_in  = QCNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_BITS]) begin
            rem_in = trial;
            num_in = {num_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            num_in = {num_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - QCNT_BITS'(1);
         if (cnt_ff == QCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = neg_ff ? -$signed(num_ff) : $signed(num_ff);
   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// ===== rtl/npc_lerp_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npc_lerp_unit
// shared interpolation unit: a + ((b - a) * s) / 2^F, saturated, two stages
// ----------------------------------------------------------------------------
module npc_lerp_unit (
   input  wire logic               clock,
   input  wire npc_pkg::coord_type a,
   input  wire npc_pkg::coord_type b,
   input  wire npc_pkg::coord_type s,
   output      npc_pkg::coord_type result
);
   import npc_pkg::*;

   localparam int PROD_BITS = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS:0]    diff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   coord_type                     a_ff;
   logic signed [PROD_BITS-1:0]   scaled;
   logic signed [PROD_BITS-1:0]   biased;
   logic signed [PROD_BITS-1:0]   total;

   always_comb begin
      diff    = $signed({b[COORD_BITS-1], b}) - $signed({a[COORD_BITS-1], a});
      prod_in = PROD_BITS'(diff) * PROD_BITS'(s);
      // truncate toward zero: bias negative products before the shift
      biased  = prod_ff[PROD_BITS-1] ?
                prod_ff + PROD_BITS'((64'sd1 <<< FRACTION_BITS) - 64'sd1) : prod_ff;
      scaled  = biased >>> FRACTION_BITS;
      total   = scaled + PROD_BITS'(a_ff);
      if (total > PROD_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1)) begin
         result = coord_type'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
      end else if (total < -PROD_BITS'(64'sd1 <<< (COORD_BITS - 1))) begin
         result = coord_type'(-(64'sd1 <<< (COORD_BITS - 1)));
      end else begin
         result = total[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
   end
endmodule
`default_nettype wire

// ===== rtl/npc_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// npc_sequencer
// vertex store, classification and the control that drives divider and lerp
// ----------------------------------------------------------------------------
module npc_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   npc_vertex_if.sink                               req,
   npc_result_if.source                             rsp,
   output      logic                                div_start,
   output      logic signed [npc_pkg::DIV_BITS-1:0] div_dividend,
   output      logic signed [npc_pkg::DIV_BITS-1:0] div_divisor,
   input  wire npc_pkg::div_ctl_type                div_ctl,
   input  wire logic signed [npc_pkg::DIV_BITS-1:0] div_quotient,
   output      npc_pkg::coord_type                  lerp_a,
   output      npc_pkg::coord_type                  lerp_b,
   output      npc_pkg::coord_type                  lerp_s,
   input  wire npc_pkg::coord_type                  lerp_result
);
   import npc_pkg::*;

   state_type   state_ff, state_in;
   vertex_type  vtx_ff [4];
   logic [1:0]  count_ff, count_in;
   logic [2:0]  out_ff;
   logic [1:0]  step_ff, step_in;       // which move of the plan
   logic [1:0]  nmoves_ff;
   logic [1:0]  mv_a_ff [2];
   logic [1:0]  mv_b_ff [2];
   logic [1:0]  mv_d_ff [2];
   logic [1:0]  lone_ff;
   logic        has_lone_ff;
   coord_type   s_ff;
   coord_type   res_ff [6];
   logic [2:0]  comp_ff, comp_in;      // lerp issue counter
   logic [2:0]  emit_ff, emit_in;
   logic [2:0]  emit_total;
   logic [1:0]  cur_a, cur_b;
   logic signed [COORD_BITS:0] d0, d1;
   logic [1:0]  emit_slot;
   logic [1:0]  inx, ipv;

   function automatic coord_type pick(input vertex_type v, input logic [2:0] c);
      coord_type r;
      r = v.x;
      case (c)
         3'd0:    r = v.x;
         3'd1:    r = v.y;
         3'd2:    r = v.z;
         3'd3:    r = v.w;
         3'd4:    r = v.u;
         3'd5:    r = v.v;
         default: r = v.x;
      endcase
      return r;
   endfunction

   function automatic logic is_out(input vertex_type v);
      logic signed [COORD_BITS:0] d;
      d = $signed({v.z[COORD_BITS-1], v.z}) + $signed({v.w[COORD_BITS-1], v.w});
      return (v.w <= 0) || (d < 0);
   endfunction

   assign cur_a = mv_a_ff[step_ff[0]];
   assign cur_b = mv_b_ff[step_ff[0]];
   assign d0 = $signed({vtx_ff[cur_a].z[COORD_BITS-1], vtx_ff[cur_a].z})
             + $signed({vtx_ff[cur_a].w[COORD_BITS-1], vtx_ff[cur_a].w});
   assign d1 = $signed({vtx_ff[cur_b].z[COORD_BITS-1], vtx_ff[cur_b].z})
             + $signed({vtx_ff[cur_b].w[COORD_BITS-1], vtx_ff[cur_b].w});
   assign div_dividend = DIV_BITS'(d0) <<< FRACTION_BITS;
   assign div_divisor  = DIV_BITS'(d0) - DIV_BITS'(d1);
   assign lerp_a = pick(vtx_ff[cur_a], comp_ff);
   assign lerp_b = pick(vtx_ff[cur_b], comp_ff);
   assign lerp_s = s_ff;
   assign emit_total = has_lone_ff ? 3'd6 : 3'd3;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT:   if (req.valid && count_ff == 2'd2) state_in = ST_CLASSIFY;
         ST_CLASSIFY:  state_in = ST_PLAN;
         ST_PLAN: begin
            // outside mask is settled here
            if (out_ff == 3'b111) state_in = ST_COLLECT;
            else if (out_ff == 3'b000) state_in = ST_EMIT;
            else state_in = ST_DIV_START;
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (div_ctl.done) state_in = ST_LERP;
         ST_LERP: begin
            if (comp_ff == 3'd6) begin
               if (step_ff + 2'd1 < nmoves_ff) state_in = ST_DIV_START;
               else state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp.ready && emit_ff == emit_total - 3'd1) state_in = ST_COLLECT;
         end
         default:      state_in = ST_COLLECT;
      endcase
   end

   // outputs
   always_comb begin
      req.ready = (state_ff == ST_COLLECT);
      div_start = (state_ff == ST_DIV_START);
      rsp.valid = (state_ff == ST_EMIT);
      emit_slot = emit_ff[1:0];
      case (emit_ff)
         3'd3:    emit_slot = lone_ff;
         3'd4:    emit_slot = 2'd3;
         3'd5:    emit_slot = (lone_ff == 2'd2) ? 2'd0 : lone_ff + 2'd1;
         default: emit_slot = emit_ff[1:0];
      endcase
      rsp.data.vtx             = vtx_ff[emit_slot];
      rsp.data.triangle_select = (emit_ff >= 3'd3);
      rsp.data.last_of_run     = (emit_ff == emit_total - 3'd1);
      count_in = count_ff;
      if (req.valid && req.ready) count_in = (count_ff == 2'd2) ? 2'd0 : count_ff + 2'd1;
      comp_in = (state_ff == ST_LERP) ? comp_ff + 3'd1 : 3'd0;
      step_in = step_ff;
      if (state_ff == ST_PLAN) step_in = 2'd0;
      if (state_ff == ST_LERP && comp_ff == 3'd6) step_in = step_ff + 2'd1;
      emit_in = emit_ff;
      if (state_ff != ST_EMIT) emit_in = 3'd0;
      else if (rsp.ready) emit_in = emit_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) vtx_ff[count_ff] <= req.data;
      if (state_ff == ST_CLASSIFY) begin
         out_ff <= {is_out(vtx_ff[2]), is_out(vtx_ff[1]), is_out(vtx_ff[0])};
      end
      if (state_ff == ST_PLAN) begin
         // plan derived from the outside mask
         case (out_ff)
            3'b000: begin
               nmoves_ff   <= 2'd0;
               has_lone_ff <= 1'b0;
            end
            3'b001, 3'b010, 3'b100: begin
               nmoves_ff   <= 2'd2;
               has_lone_ff <= 1'b1;
               lone_ff     <= inx ^ inx ^ ((out_ff == 3'b001) ? 2'd0 :
                              (out_ff == 3'b010) ? 2'd1 : 2'd2);
               mv_a_ff[0]  <= (out_ff == 3'b001) ? 2'd0 : (out_ff == 3'b010) ? 2'd1 : 2'd2;
               mv_b_ff[0]  <= inx;
               mv_d_ff[0]  <= 2'd3;
               mv_a_ff[1]  <= (out_ff == 3'b001) ? 2'd0 : (out_ff == 3'b010) ? 2'd1 : 2'd2;
               mv_b_ff[1]  <= ipv;
               mv_d_ff[1]  <= (out_ff == 3'b001) ? 2'd0 : (out_ff == 3'b010) ? 2'd1 : 2'd2;
            end
            default: begin
               // two outside: each outside vertex, in index order, moves toward the inside one
               nmoves_ff   <= 2'd2;
               has_lone_ff <= 1'b0;
               mv_a_ff[0]  <= (out_ff == 3'b110) ? 2'd1 : 2'd0;
               mv_d_ff[0]  <= (out_ff == 3'b110) ? 2'd1 : 2'd0;
               mv_b_ff[0]  <= (out_ff == 3'b110) ? 2'd0 : (out_ff == 3'b101) ? 2'd1 : 2'd2;
               mv_a_ff[1]  <= (out_ff == 3'b011) ? 2'd1 : 2'd2;
               mv_d_ff[1]  <= (out_ff == 3'b011) ? 2'd1 : 2'd2;
               mv_b_ff[1]  <= (out_ff == 3'b110) ? 2'd0 : (out_ff == 3'b101) ? 2'd1 : 2'd2;
            end
         endcase
      end
      if (div_ctl.done) begin
         s_ff <= (div_divisor == '0) ? '0 : sat_coord(div_quotient);
      end
      // lerp result lands in the cycle after issue; buffer so the move reads old values
      if (state_ff == ST_LERP && comp_ff >= 3'd1) res_ff[comp_ff - 3'd1] <= lerp_result;
      if (state_ff == ST_LERP && comp_ff == 3'd6) begin
         vtx_ff[mv_d_ff[step_ff[0]]] <= {res_ff[0], res_ff[1], res_ff[2], res_ff[3],
                                         res_ff[4], lerp_result};
      end
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= 2'd0;
         comp_ff  <= 3'd0;
         step_ff  <= 2'd0;
         emit_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         comp_ff  <= comp_in;
         step_ff  <= step_in;
         emit_ff  <= emit_in;
      end
   end

   // neighbors of the lone outside vertex, used only by the one-outside plan
   always_comb begin
      inx = 2'd1;
      ipv = 2'd2;
      case (out_ff)
         3'b010:  begin inx = 2'd2; ipv = 2'd0; end
         3'b100:  begin inx = 2'd0; ipv = 2'd1; end
         default: begin inx = 2'd1; ipv = 2'd2; end
      endcase
   end

   a_ready_collect: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("input taken while emitting");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("corner count out of range");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> emit_ff < emit_total) else $error("emit index past end");
   a_div_only_planned: assert property (@(posedge clock) disable iff (reset)
      div_start |-> nmoves_ff != 2'd0) else $error("divide with no move");
endmodule
`default_nettype wire

// ===== rtl/near_plane_triangle_clipper_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// near_plane_triangle_clipper_top
// clips a clip-space triangle against the near plane z + w = 0
// ----------------------------------------------------------------------------
// usage:
//   req_ takes one vertex item per handshake; three items make a triangle.
//   rsp_ returns 0, 3 or 6 vertex items for the third vertex, three per
//   triangle, last_of_run set on the final one.
//   the first two vertices are only stored. the third starts a sequence
//   of classify and plan, then per moved vertex one serial divide and
//   six lerps on the shared multiplier, then the emitted items, one per
//   cycle while rsp_ready is high. the divider produces one quotient bit
//   per cycle. req_ready is low from the third vertex until the last
//   result is taken, or until after the plan when all three are outside.
//   a stalled rsp_ready holds the current item; nothing else moves meanwhile.
//   reset is synchronous: the corner count returns to zero and any partial
//   triangle is dropped.
// ----------------------------------------------------------------------------
module near_plane_triangle_clipper_top (
   input  wire logic clock,
   input  wire logic reset,
   npc_vertex_if.sink   req,
   npc_result_if.source rsp
);
   import npc_pkg::*;

   logic                        div_start;
   logic signed [DIV_BITS-1:0]  div_dividend;
   logic signed [DIV_BITS-1:0]  div_divisor;
   logic signed [DIV_BITS-1:0]  div_quotient;
   div_ctl_type                 div_ctl;
   coord_type                   lerp_a, lerp_b, lerp_s, lerp_result;

   npc_sequencer u_seq (
      .clock, .reset, .req, .rsp,
      .div_start, .div_dividend, .div_divisor, .div_ctl, .div_quotient,
      .lerp_a, .lerp_b, .lerp_s, .lerp_result
   );

   npc_divider u_div (
      .clock, .reset,
      .start(div_start), .dividend(div_dividend), .divisor(div_divisor),
      .ctl(div_ctl), .quotient(div_quotient)
   );

   npc_lerp_unit u_lerp (
      .clock, .a(lerp_a), .b(lerp_b), .s(lerp_s), .result(lerp_result)
   );
endmodule
`default_nettype wire

// ===== tb/tb_clip_if.sv =====
// ----------------------------------------------------------------------------
// tb_clip_if
// no extra interfaces are needed: the block's own channel interfaces are used
// ----------------------------------------------------------------------------
package tb_clip_pkg;
   timeunit 1ns;
   timeprecision 1ps;
   localparam int WATCHDOG_CYCLES = 20000;
endpackage

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// feeds triangles to the near-plane clipper and checks every emitted vertex
// against an in-bench clipper model, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import npc_pkg::*;
   import tb_clip_pkg::*;

   typedef longint signed wide_t;

   logic clock;
   logic reset;
   npc_vertex_if req ();
   npc_result_if rsp ();

   near_plane_triangle_clipper_top dut (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // model state: four vertex slots of x, y, z, w, u, v
   wide_t      corner_store [4][6];
   int         corners_held;
   result_type vertex_queue [$];
   int         fail_count;
   int         idle_cycles;
   bit         stim_done;
   bit         hold_off;

   function automatic wide_t clamp_coord(wide_t v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic wide_t near_dist(int k);
      return corner_store[k][2] + corner_store[k][3];
   endfunction

   task automatic slide_vertex(int a, int b, int dst);
      wide_t d0, d1, den, s, moved [6];
      d0  = near_dist(a);
      d1  = near_dist(b);
      den = d0 - d1;
      s   = 0;
      if (den != 0) s = clamp_coord((d0 * 65536) / den);
      for (int c = 0; c < 6; c++)
         moved[c] = clamp_coord(corner_store[a][c] +
                                ((corner_store[b][c] - corner_store[a][c]) * s) / 65536);
      for (int c = 0; c < 6; c++) corner_store[dst][c] = moved[c];
   endtask

   function automatic result_type pack_vertex(int k, bit tri_sel, bit last);
      result_type r;
      r.vtx.x = coord_type'(corner_store[k][0]);
      r.vtx.y = coord_type'(corner_store[k][1]);
      r.vtx.z = coord_type'(corner_store[k][2]);
      r.vtx.w = coord_type'(corner_store[k][3]);
      r.vtx.u = coord_type'(corner_store[k][4]);
      r.vtx.v = coord_type'(corner_store[k][5]);
      r.triangle_select = tri_sel;
      r.last_of_run = last;
      return r;
   endfunction

   task automatic clip_vertex(vertex_type vin);
      bit out_flag [3];
      int n_out, lone, nx, pv;
      corner_store[corners_held][0] = wide_t'(vin.x);
      corner_store[corners_held][1] = wide_t'(vin.y);
      corner_store[corners_held][2] = wide_t'(vin.z);
      corner_store[corners_held][3] = wide_t'(vin.w);
      corner_store[corners_held][4] = wide_t'(vin.u);
      corner_store[corners_held][5] = wide_t'(vin.v);
      if (corners_held < 2) begin
         corners_held++;
         return;
      end
      corners_held = 0;
      n_out = 0;
      lone = -1;
      for (int i = 0; i < 3; i++) begin
         out_flag[i] = corner_store[i][3] <= 0 || near_dist(i) < 0;
         if (out_flag[i]) n_out++;
      end
      if (n_out == 3) return;
      if (n_out > 0) begin
         for (int i = 0; i < 3; i++) begin
            nx = (i + 1) % 3;
            pv = (i + 2) % 3;
            if (!out_flag[i]) continue;
            if (out_flag[nx]) begin
               slide_vertex(i, pv, i);
            end else if (out_flag[pv]) begin
               slide_vertex(i, nx, i);
            end else begin
               slide_vertex(i, nx, 3);
               slide_vertex(i, pv, i);
               lone = i;
               break;
            end
         end
      end
      vertex_queue.push_back(pack_vertex(0, 0, 0));
      vertex_queue.push_back(pack_vertex(1, 0, 0));
      vertex_queue.push_back(pack_vertex(2, 0, lone < 0));
      if (lone >= 0) begin
         vertex_queue.push_back(pack_vertex(lone, 1, 0));
         vertex_queue.push_back(pack_vertex(3, 1, 0));
         vertex_queue.push_back(pack_vertex((lone + 1) % 3, 1, 1));
      end
   endtask

   function automatic int gap_len();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
      return $urandom_range(0, 3);
   endfunction

   function automatic coord_type edge_coord();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return coord_type'($urandom);
         default: return coord_type'($urandom_range(0, 32'h40000)) - 32'sh20000;
      endcase
   endfunction

   // mostly well-behaved vertices around the near plane, some wild ones
   function automatic vertex_type rand_vertex();
      vertex_type v;
      v.x = coord_type'($urandom);
      v.y = coord_type'($urandom);
      v.u = coord_type'($urandom);
      v.v = coord_type'($urandom);
      if ($urandom_range(0, 5) == 0) begin
         v.z = edge_coord();
         v.w = edge_coord();
      end else begin
         v.w = coord_type'($urandom_range(0, 32'h80000)) - 32'sh10000;
         v.z = coord_type'($urandom_range(0, 32'h100000)) - 32'sh80000;
      end
      return v;
   endfunction

   function automatic vertex_type mk(int z, int w);
      vertex_type v;
      v.x = coord_type'($urandom);
      v.y = coord_type'($urandom);
      v.z = coord_type'(z);
      v.w = coord_type'(w);
      v.u = coord_type'($urandom);
      v.v = coord_type'($urandom);
      return v;
   endfunction

   localparam int ONE = 32'sh10000;
   localparam int DIRECTED_N = 24;
   vertex_type directed_rows [DIRECTED_N];
   result_type expected_first;

   initial begin
      // all inside, with extreme x/y/u/v read back unchanged
      directed_rows[0]  = '{32'sh7fffffff, 32'sh80000000, 0, ONE,
                            32'sh80000000, 32'sh7fffffff};
      directed_rows[1]  = '{32'sh80000000, 32'sh7fffffff, ONE, ONE, 0, -1};
      directed_rows[2]  = '{-1, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0};
      // all outside
      directed_rows[3]  = mk(0, 0);
      directed_rows[4]  = mk(32'sh80000000, 32'sh80000000);
      directed_rows[5]  = mk(-2 * ONE, ONE);
      // two outside
      directed_rows[6]  = mk(0, 2 * ONE);
      directed_rows[7]  = mk(-3 * ONE, ONE);
      directed_rows[8]  = mk(ONE, -ONE);
      // one outside, each position
      directed_rows[9]  = mk(-2 * ONE, ONE);
      directed_rows[10] = mk(ONE, ONE);
      directed_rows[11] = mk(0, ONE);
      directed_rows[12] = mk(0, ONE);
      directed_rows[13] = mk(0, -ONE);
      directed_rows[14] = mk(ONE, 2 * ONE);
      directed_rows[15] = mk(0, ONE);
      directed_rows[16] = mk(ONE, ONE);
      directed_rows[17] = mk(32'sh7fffffff, 32'sh80000000);
      // equal distances: zero divisor, plus extreme z and w values
      directed_rows[18] = mk(ONE, 0);
      directed_rows[19] = mk(ONE, 0);
      directed_rows[20] = mk(0, ONE);
      directed_rows[21] = mk(32'sh7fffffff, 32'sh80000001);
      directed_rows[22] = mk(32'sh80000000, 32'sh7fffffff);
      directed_rows[23] = mk(32'sh7fffffff, 32'sh7fffffff);
      expected_first = '{directed_rows[0], 1'b0, 1'b0};
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // valid is dropped only when a gap follows, so back-to-back items keep it high
   task automatic send_vertex(vertex_type v);
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data  <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      clip_vertex(v);
   endtask

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < DIRECTED_N; i++) send_vertex(directed_rows[i]);
      for (int i = 0; i < 387; i++) send_vertex(rand_vertex());
      req.valid <= 1'b0;
      stim_done = 1;
   end

   // long receiver hold-off so the block fills up and stalls its input
   initial begin
      repeat (400) @(posedge clock);
      hold_off = 1;
      repeat (600) @(posedge clock);
      hold_off = 0;
   end

   initial begin
      int g;
      rsp.ready = 1'b0;
      @(posedge clock);
      forever begin
         g = gap_len();
         if (g > 0) begin
            rsp.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp.ready <= !hold_off;
         @(posedge clock);
      end
   end

   int checked_count;
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (vertex_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected vertex item %p", rsp.data);
         end else begin
            want = vertex_queue.pop_front();
            if (checked_count == 0 && want != expected_first) begin
               fail_count++;
               if (fail_count <= 10) $display("model disagrees with first table row");
            end
            if (rsp.data !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("vertex mismatch: expected %p actual %p", want, rsp.data);
            end
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (stim_done && vertex_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      @(posedge clock);
      wait (idle_cycles >= WATCHDOG_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end
endmodule
